// ===== hdl/i2cbc_pkg.sv =====
// types and constants for the i2c bus-clear sequencer
// used by i2c_bus_clear_sequencer; no dependencies
`default_nettype none

package i2cbc_pkg;

    localparam int PULSE_LIMIT_DEF  = 9;
    localparam int HALF_W           = 16;
    localparam int TIMER_W          = 24;
    localparam int CNT_W            = 4;
    localparam int APB_DW           = 32;
    localparam int APB_AW           = 3;

    localparam logic [HALF_W-1:0]  HALF_RST    = 16'd5;
    localparam logic [TIMER_W-1:0] TIMEOUT_RST = 24'd1000;

    typedef enum logic [0:0] {
        REG_HALF_PERIOD = 1'b0,
        REG_TIMEOUT     = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_WAIT_INIT    = 4'd1,
        PH_PULSE_LOW    = 4'd2,
        PH_WAIT_PULSE   = 4'd3,
        PH_PULSE_HIGH   = 4'd4,
        PH_STOP_SCL_LOW = 4'd5,
        PH_STOP_SDA_LOW = 4'd6,
        PH_STOP_WAIT    = 4'd7,
        PH_STOP_HOLD    = 4'd8,
        PH_STOP_REL     = 4'd9
    } t_phase;

    typedef struct packed {
        logic start_req;
        logic sda_level;
        logic scl_level;
    } t_in_word;

    typedef struct packed {
        logic             scl_pull_low;
        logic             sda_pull_low;
        logic             busy_res;
        logic             done_res;
        logic             status;
        logic [CNT_W-1:0] pulses_sent;
    } t_out_word;

endpackage

`default_nettype wire

// ===== hdl/i2c_bus_clear_sequencer.sv =====
// i2c bus-clear sequencer: one output word for each input word accepted
// output valid the cycle after accept; 1 input word per cycle unless stalled
// the phase, pulse count and tick timer advance in the same cycle as the accept
// sync active-low reset: idle, count and timer cleared, registers at defaults
// depends on i2cbc_pkg
`default_nettype none

module i2c_bus_clear_sequencer #(
    parameter int PULSE_LIMIT = i2cbc_pkg::PULSE_LIMIT_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire i2cbc_pkg::t_in_word            i_in_word,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output i2cbc_pkg::t_out_word                o_out_word,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [i2cbc_pkg::APB_AW-1:0]         paddr,
    input  wire [i2cbc_pkg::APB_DW-1:0]         pwdata,
    output logic [i2cbc_pkg::APB_DW-1:0]        prdata,
    output logic                                pready
);

    localparam int HW = i2cbc_pkg::HALF_W;
    localparam int TW = i2cbc_pkg::TIMER_W;
    localparam int CW = i2cbc_pkg::CNT_W;
    localparam int DW = i2cbc_pkg::APB_DW;

    i2cbc_pkg::t_phase    r_phase, n_phase;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [TW-1:0]        r_timer, n_timer;
    logic [HW-1:0]        r_half;
    logic [TW-1:0]        r_timeout;
    logic                 r_out_valid;
    i2cbc_pkg::t_out_word r_out_word, n_word;

    logic                 in_acc;
    logic                 cfg_wr;
    i2cbc_pkg::t_reg_idx  reg_idx;
    logic [HW-1:0]        hp;
    logic [TW-1:0]        timer_inc;
    logic                 half_done;
    logic                 timed_out;
    logic                 done;
    logic                 stuck;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign reg_idx     = i2cbc_pkg::t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (reg_idx)
            i2cbc_pkg::REG_HALF_PERIOD: prdata = DW'(r_half);
            i2cbc_pkg::REG_TIMEOUT:     prdata = DW'(r_timeout);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= i2cbc_pkg::HALF_RST;
            r_timeout <= i2cbc_pkg::TIMEOUT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                i2cbc_pkg::REG_HALF_PERIOD: r_half    <= pwdata[HW-1:0];
                i2cbc_pkg::REG_TIMEOUT:     r_timeout <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    assign hp        = (r_half == '0) ? HW'(1) : r_half;
    assign timer_inc = r_timer + TW'(1);
    assign half_done = timer_inc >= TW'(hp);
    assign timed_out = r_timer >= r_timeout;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_timer = r_timer;
        done    = 1'b0;
        stuck   = 1'b0;
        unique case (r_phase) inside
            i2cbc_pkg::PH_IDLE: begin
                if (i_in_word.start_req) begin
                    n_cnt   = '0;
                    n_phase = i2cbc_pkg::PH_WAIT_INIT;
                    n_timer = '0;
                end
            end
            i2cbc_pkg::PH_WAIT_INIT: begin
                if (i_in_word.scl_level) begin
                    if (i_in_word.sda_level) begin
                        done = 1'b1;
                    end else begin
                        n_cnt   = CW'(1);
                        n_phase = i2cbc_pkg::PH_PULSE_LOW;
                        n_timer = '0;
                    end
                end else if (timed_out) begin
                    done  = 1'b1;
                    stuck = 1'b1;
                end else begin
                    n_timer = timer_inc;
                end
            end
            i2cbc_pkg::PH_WAIT_PULSE, i2cbc_pkg::PH_STOP_WAIT: begin
                if (i_in_word.scl_level) begin
                    n_phase = (r_phase == i2cbc_pkg::PH_WAIT_PULSE) ?
                              i2cbc_pkg::PH_PULSE_HIGH : i2cbc_pkg::PH_STOP_HOLD;
                    n_timer = '0;
                end else if (timed_out) begin
                    done  = 1'b1;
                    stuck = 1'b1;
                end else begin
                    n_timer = timer_inc;
                end
            end
            i2cbc_pkg::PH_PULSE_HIGH: begin
                n_timer = timer_inc;
                if (half_done) begin
                    n_timer = '0;
                    if (!i_in_word.sda_level && (r_cnt < CW'(PULSE_LIMIT))) begin
                        n_cnt   = r_cnt + CW'(1);
                        n_phase = i2cbc_pkg::PH_PULSE_LOW;
                    end else begin
                        n_phase = i2cbc_pkg::PH_STOP_SCL_LOW;
                    end
                end
            end
            i2cbc_pkg::PH_PULSE_LOW, i2cbc_pkg::PH_STOP_SCL_LOW,
            i2cbc_pkg::PH_STOP_SDA_LOW, i2cbc_pkg::PH_STOP_HOLD: begin
                n_timer = timer_inc;
                if (half_done) begin
                    n_timer = '0;
                    unique case (r_phase)
                        i2cbc_pkg::PH_PULSE_LOW:    n_phase = i2cbc_pkg::PH_WAIT_PULSE;
                        i2cbc_pkg::PH_STOP_SCL_LOW: n_phase = i2cbc_pkg::PH_STOP_SDA_LOW;
                        i2cbc_pkg::PH_STOP_SDA_LOW: n_phase = i2cbc_pkg::PH_STOP_WAIT;
                        default:                    n_phase = i2cbc_pkg::PH_STOP_REL;
                    endcase
                end
            end
            i2cbc_pkg::PH_STOP_REL: begin
                n_timer = timer_inc;
                if (half_done) begin
                    done  = 1'b1;
                    stuck = !(i_in_word.sda_level && i_in_word.scl_level);
                end
            end
            default: begin
                n_phase = i2cbc_pkg::PH_IDLE;
                n_timer = '0;
            end
        endcase

        if (done) begin
            n_phase = i2cbc_pkg::PH_IDLE;
            n_timer = '0;
        end

        n_word.scl_pull_low = (n_phase == i2cbc_pkg::PH_PULSE_LOW) ||
                              (n_phase == i2cbc_pkg::PH_STOP_SCL_LOW) ||
                              (n_phase == i2cbc_pkg::PH_STOP_SDA_LOW);
        n_word.sda_pull_low = (n_phase == i2cbc_pkg::PH_STOP_SDA_LOW) ||
                              (n_phase == i2cbc_pkg::PH_STOP_WAIT) ||
                              (n_phase == i2cbc_pkg::PH_STOP_HOLD);
        n_word.busy_res     = (n_phase != i2cbc_pkg::PH_IDLE);
        n_word.done_res     = done;
        n_word.status       = done && stuck;
        n_word.pulses_sent  = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cbc_pkg::PH_IDLE;
            r_cnt   <= '0;
            r_timer <= '0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_word <= n_word;
        end
    end

endmodule

`default_nettype wire
